/* rtl/pis_pkg.sv */
// Shared types, constants and saturating fixed-point helpers for the particle integrator.
// Depends on nothing; every other file imports it.
package pis_pkg;

  localparam int unsigned VW    = 32;
  localparam int unsigned FB    = 16;
  localparam int unsigned DT_W  = 9;
  localparam int unsigned NLANE = 3;

  typedef logic signed [VW-1:0]   val_t;
  typedef logic signed [2*VW-1:0] wide_t;
  typedef logic [DT_W-1:0]        dt_t;

  localparam val_t        VAL_MAX   = {1'b0, {(VW-1){1'b1}}};
  localparam val_t        VAL_MIN   = {1'b1, {(VW-1){1'b0}}};
  localparam wide_t       RND_HALF  = {{(2*VW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam wide_t       RND_HALFM = {{(2*VW-FB+1){1'b0}}, {(FB-1){1'b1}}};
  localparam logic [15:0] FT_LIMIT  = 16'd3276;
  localparam logic [12:0] DT_RECIP  = 13'd6554;
  localparam logic [16:0] DT_BIAS   = 17'd5;
  localparam val_t        FB_THRESH = val_t'(((2**FB) - 1) / 100);
  localparam val_t        AMP_RESET  = val_t'(65536);
  localparam val_t        REST_RESET = val_t'(6881280);

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_AMP  = 2'd1,
    REG_REST = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_EULER  = 2'd0,
    MODE_CROMER = 2'd1,
    MODE_VERLET = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BR_EULER  = 2'd0,
    BR_CROMER = 2'd1,
    BR_VERLET = 2'd2
  } branch_e;

  typedef enum logic [2:0] {
    MS_NONE = 3'd0,
    MS_PP   = 3'd1,
    MS_QQ   = 3'd2,
    MS_PA   = 3'd3,
    MS_FS   = 3'd4,
    MS_RD   = 3'd5,
    MS_VD   = 3'd6
  } mul_sel_e;

  typedef enum logic [3:0] {
    WB_NONE  = 4'd0,
    WB_LOAD  = 4'd1,
    WB_INIT  = 4'd2,
    WB_SAVE  = 4'd3,
    WB_EUL   = 4'd4,
    WB_VEL   = 4'd5,
    WB_POS   = 4'd6,
    WB_DIFF  = 4'd7,
    WB_DACC  = 4'd8,
    WB_PDIFF = 4'd9
  } wb_op_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     rnd_en;
    wb_op_e   wb;
    logic     prev_wr;
  } lane_ctl_t;

  typedef struct packed {
    logic sum_en;
    logic sub_en;
    logic fb_en;
  } merge_ctl_t;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]       frame_time;
  } pis_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic              skipped;
  } pis_out_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? VAL_MIN : VAL_MAX;
    end
    return s[VW-1:0];
  endfunction

  function automatic val_t sat_sub(val_t a, val_t b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? VAL_MIN : VAL_MAX;
    end
    return s[VW-1:0];
  endfunction

  function automatic val_t sat_neg(val_t a);
    if (a == VAL_MIN) begin
      return VAL_MAX;
    end
    return -a;
  endfunction

  // round half away from zero, drop fraction bits, saturate
  function automatic val_t mul_round(wide_t p);
    wide_t b;
    wide_t sh;
    b  = p + (p[2*VW-1] ? RND_HALFM : RND_HALF);
    sh = b >>> FB;
    if (!sh[2*VW-1] && (|sh[2*VW-2:VW-1])) begin
      return VAL_MAX;
    end
    if (sh[2*VW-1] && !(&sh[2*VW-2:VW-1])) begin
      return VAL_MIN;
    end
    return sh[VW-1:0];
  endfunction

endpackage

/* rtl/pis_lane.sv */
// One coordinate lane: holds direction, velocity, previous and working position,
// with a registered multiplier and rounding stage. Depends on pis_pkg.
module pis_lane import pis_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  val_t      pos_i,
  input  val_t      amp_i,
  input  val_t      s_i,
  input  dt_t       dt_i,
  output val_t      pos_o,
  output val_t      r_o
);

  val_t  fd_q, fd_d;
  val_t  vel_q, vel_d;
  val_t  prev_q, prev_d;
  val_t  p_q, p_d;
  val_t  ad_q, ad_d;
  val_t  r_q;
  wide_t prod_q;
  val_t  op_a, op_b, dt_v;
  wide_t mul_w;

  assign dt_v = val_t'({{(VW-DT_W){1'b0}}, dt_i});

  always_comb begin
    case (ctl_i.mul_sel)
      MS_PP:   begin op_a = p_q;    op_b = p_q;    end
      MS_QQ:   begin op_a = prev_q; op_b = prev_q; end
      MS_PA:   begin op_a = p_q;    op_b = amp_i;  end
      MS_FS:   begin op_a = fd_q;   op_b = s_i;    end
      MS_RD:   begin op_a = r_q;    op_b = dt_v;   end
      MS_VD:   begin op_a = vel_q;  op_b = dt_v;   end
      default: begin op_a = '0;     op_b = '0;     end
    endcase
  end

  assign mul_w = op_a * op_b;

  always_comb begin
    fd_d   = fd_q;
    vel_d  = vel_q;
    p_d    = p_q;
    ad_d   = ad_q;
    prev_d = ctl_i.prev_wr ? p_q : prev_q;
    unique case (ctl_i.wb)
      WB_NONE:  ;
      WB_LOAD:  p_d = pos_i;
      WB_INIT:  begin
        fd_d  = sat_neg(p_q);
        vel_d = r_q;
      end
      WB_SAVE:  ad_d = r_q;
      WB_EUL:   begin
        vel_d = sat_add(vel_q, ad_q);
        p_d   = sat_add(p_q, r_q);
      end
      WB_VEL:   vel_d = sat_add(vel_q, r_q);
      WB_POS:   p_d = sat_add(p_q, r_q);
      WB_DIFF:  ad_d = sat_sub(p_q, prev_q);
      WB_DACC:  ad_d = sat_add(ad_q, r_q);
      WB_PDIFF: p_d = sat_add(p_q, ad_q);
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_q   <= '0;
      vel_q  <= '0;
      prev_q <= '0;
    end else begin
      fd_q   <= fd_d;
      vel_q  <= vel_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    ad_q <= ad_d;
    if (ctl_i.mul_sel != MS_NONE) begin
      prod_q <= mul_w;
    end
    if (ctl_i.rnd_en) begin
      r_q <= mul_round(prod_q);
    end
  end

  assign pos_o = p_q;
  assign r_o   = r_q;

endmodule

/* rtl/pis_merge.sv */
// Merge stage: sums the lanes' squared terms, forms the spring scale and
// the Verlet fallback flag. Depends on pis_pkg.
module pis_merge import pis_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  merge_ctl_t ctl_i,
  input  val_t       r_i [NLANE],
  input  val_t       rest_i,
  output val_t       s_o,
  output logic       fb_o
);

  val_t sum_q, s_q;
  logic fb_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q <= sat_add(sat_add(r_i[0], r_i[1]), r_i[2]);
    end
    if (ctl_i.sub_en) begin
      s_q <= sat_sub(sum_q, rest_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q <= 1'b0;
    end else if (ctl_i.fb_en) begin
      fb_q <= (sum_q <= FB_THRESH);
    end
  end

  assign s_o  = s_q;
  assign fb_o = fb_q;

endmodule

/* rtl/particle_integrator_step.sv */
// Particle integrator top level: handshake, configuration registers, sequencer,
// three coordinate lanes and merge stage. Depends on pis_pkg, pis_lane, pis_merge.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one word per item:
//   an init word (req_type 0) or a step word (req_type 1). Output channel
//   out_valid_o / out_stall_i / out_data_o returns exactly one word per item.
//   Configuration writes arrive on cfg_valid_i / cfg_ready_o with cfg_index_i
//   (0 mode, 1 amplitude, 2 rest level) and cfg_data_i; ready is always high.
//   One item is in work at a time; x, y and z run in three lanes, each with
//   one registered 32x32 multiplier followed by a rounding register.
//   A step runs the multiply/round pairs of the sequencer, an init a single
//   multiply, round and write-back, and a skipped frame or mode three goes
//   straight to the output state. The next item is taken in the cycle after
//   the result moves into the output register, so items never share the lanes.
//   A result waiting in the output register does not block the next item;
//   a stalled receiver holds the word and only the following result waits.
//   Reset clears direction, velocity and previous position to zero, sets
//   mode Euler, amplitude 1.0 and rest level 105.0.
module particle_integrator_step import pis_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pis_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pis_out_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_MPP  = 17'h00002,
    ST_RPP  = 17'h00004,
    ST_MQQ  = 17'h00008,
    ST_RQQ  = 17'h00010,
    ST_MFS  = 17'h00020,
    ST_RFS  = 17'h00040,
    ST_MAD  = 17'h00080,
    ST_RAD  = 17'h00100,
    ST_B0   = 17'h00200,
    ST_B1   = 17'h00400,
    ST_B2   = 17'h00800,
    ST_B3   = 17'h01000,
    ST_IM   = 17'h02000,
    ST_IR   = 17'h04000,
    ST_IW   = 17'h08000,
    ST_OUT  = 17'h10000
  } state_e;

  state_e     state_q, state_d;
  mode_e      mode_q;
  val_t       amp_q, rest_q;
  dt_t        dt_q;
  logic       skip_q;
  logic       out_valid_q;
  pis_out_t   out_q;
  logic       in_acc, out_load, ft_long;
  logic [29:0] dt_prod;
  branch_e    br;
  lane_ctl_t  lctl;
  merge_ctl_t mctl;
  val_t       s_w;
  logic       fb_w;
  val_t       lane_pos [NLANE];
  val_t       lane_r   [NLANE];
  val_t       lane_in  [NLANE];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign ft_long     = (in_data_i.frame_time > FT_LIMIT);
  assign dt_prod     = ({13'd0, {1'b0, in_data_i.frame_time} + DT_BIAS}) * {17'd0, DT_RECIP};
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign lane_in[0] = in_data_i.pos_x;
  assign lane_in[1] = in_data_i.pos_y;
  assign lane_in[2] = in_data_i.pos_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EULER;
      amp_q  <= AMP_RESET;
      rest_q <= REST_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODE: mode_q <= mode_e'(cfg_data_i[1:0]);
        REG_AMP:  amp_q  <= cfg_data_i;
        REG_REST: rest_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (mode_q)
      MODE_EULER:  br = BR_EULER;
      MODE_CROMER: br = BR_CROMER;
      default:     br = fb_w ? BR_CROMER : BR_VERLET;
    endcase
  end

  always_comb begin
    state_d = state_q;
    lctl    = '{mul_sel: MS_NONE, rnd_en: 1'b0, wb: WB_NONE, prev_wr: 1'b0};
    mctl    = '{sum_en: 1'b0, sub_en: 1'b0, fb_en: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          lctl.wb = WB_LOAD;
          if (!in_data_i.req_type) begin
            state_d = ST_IM;
          end else if (ft_long || mode_q == MODE_NONE) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_MPP;
          end
        end
      end
      ST_MPP: begin
        lctl.mul_sel = MS_PP;
        state_d      = ST_RPP;
      end
      ST_RPP: begin
        lctl.rnd_en = 1'b1;
        state_d     = ST_MQQ;
      end
      ST_MQQ: begin
        lctl.mul_sel = MS_QQ;
        mctl.sum_en  = 1'b1;
        state_d      = ST_RQQ;
      end
      ST_RQQ: begin
        lctl.rnd_en = 1'b1;
        mctl.sub_en = 1'b1;
        state_d     = ST_MFS;
      end
      ST_MFS: begin
        lctl.mul_sel = MS_FS;
        mctl.sum_en  = 1'b1;
        state_d      = ST_RFS;
      end
      ST_RFS: begin
        lctl.rnd_en = 1'b1;
        mctl.fb_en  = 1'b1;
        state_d     = ST_MAD;
      end
      ST_MAD: begin
        lctl.mul_sel = MS_RD;
        state_d      = ST_RAD;
      end
      ST_RAD: begin
        lctl.rnd_en = 1'b1;
        state_d     = ST_B0;
      end
      ST_B0: begin
        lctl.prev_wr = (mode_q == MODE_VERLET);
        case (br)
          BR_EULER: begin
            lctl.mul_sel = MS_VD;
            lctl.wb      = WB_SAVE;
          end
          BR_CROMER: lctl.wb = WB_VEL;
          default: begin
            lctl.mul_sel = MS_RD;
            lctl.wb      = WB_DIFF;
          end
        endcase
        state_d = ST_B1;
      end
      ST_B1: begin
        if (br == BR_CROMER) begin
          lctl.mul_sel = MS_VD;
        end else begin
          lctl.rnd_en = 1'b1;
        end
        state_d = ST_B2;
      end
      ST_B2: begin
        case (br)
          BR_EULER:  lctl.wb     = WB_EUL;
          BR_CROMER: lctl.rnd_en = 1'b1;
          default:   lctl.wb     = WB_DACC;
        endcase
        state_d = ST_B3;
      end
      ST_B3: begin
        case (br)
          BR_CROMER: lctl.wb = WB_POS;
          BR_VERLET: lctl.wb = WB_PDIFF;
          default:   ;
        endcase
        state_d = ST_OUT;
      end
      ST_IM: begin
        lctl.mul_sel = MS_PA;
        state_d      = ST_IR;
      end
      ST_IR: begin
        lctl.rnd_en = 1'b1;
        state_d     = ST_IW;
      end
      ST_IW: begin
        lctl.wb = WB_INIT;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q   <= dt_prod[16+DT_W-1:16];
      skip_q <= !in_data_i.req_type || ft_long;
    end
    if (out_load) begin
      out_q <= '{new_x: lane_pos[0], new_y: lane_pos[1], new_z: lane_pos[2],
                 skipped: skip_q};
    end
  end

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    pis_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lctl),
      .pos_i  (lane_in[g]),
      .amp_i  (amp_q),
      .s_i    (s_w),
      .dt_i   (dt_q),
      .pos_o  (lane_pos[g]),
      .r_o    (lane_r[g])
    );
  end

  pis_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mctl),
    .r_i    (lane_r),
    .rest_i (rest_q),
    .s_o    (s_w),
    .fb_o   (fb_w)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && out_stall_i) |=> state_q == ST_OUT)
    else $error("result left the lanes while the output word was still held");

  a_init_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_data_i.req_type) |=> state_q == ST_IM)
    else $error("init word did not start the init sequence");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("output word raised outside the output state");
`endif

endmodule

/* tb/sv/tb_particle_integrator_step.sv */
// Self-checking testbench for particle_integrator_step: directed table, then random phases.
// Predicts each result with its own Q16.16 integrator; depends on pis_pkg and the RTL only.
module tb_particle_integrator_step;
  timeunit 1ns;
  timeprecision 1ps;
  import pis_pkg::*;

  localparam int         ONE           = 65536;
  localparam int         FRAME_MAX     = 3276;
  localparam longint     VERLET_MIN_SQ = (ONE - 1) / 100;
  localparam int         LIMIT         = 200000;
  localparam int         RANDOM_WORDS  = 400;
  localparam logic       REQ_INIT      = 1'b0;
  localparam logic       REQ_STEP      = 1'b1;
  localparam logic [1:0] REG_SPARE     = 2'd3;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [31:0] data;
    pis_in_t     word;
    logic        known;
    pis_out_t    want;
  } plan_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  pis_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pis_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  pis_out_t  expected_q[$];
  plan_row_t plan[$];

  mode_e mode_q;
  val_t  amp_q;
  val_t  rest_q;
  val_t  dir_v[3];
  val_t  vel_v[3];
  val_t  prev_v[3];
  val_t  track[3];

  int burst_left = 0;
  int gap_max    = 0;
  int stall_left = 0;
  int stall_kind = 0;
  int errors     = 0;
  int results    = 0;
  int skips      = 0;
  int inits      = 0;
  int steps      = 0;
  int cfg_writes = 0;
  int cycles     = 0;

  particle_integrator_step DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic val_t clamp_q(longint v);
    if (v > longint'(VAL_MAX)) return VAL_MAX;
    if (v < longint'(VAL_MIN)) return VAL_MIN;
    return val_t'(v);
  endfunction

  function automatic val_t q_add(val_t a, val_t b);
    return clamp_q(longint'(a) + longint'(b));
  endfunction

  function automatic val_t q_sub(val_t a, val_t b);
    return clamp_q(longint'(a) - longint'(b));
  endfunction

  // round the magnitude half up, so ties move away from zero
  function automatic val_t q_mul(val_t a, val_t b);
    longint prod;
    longint mag;
    longint q;
    prod = longint'(a) * longint'(b);
    mag  = (prod < 0) ? -prod : prod;
    q    = (mag + 64'sd32768) >> 16;
    if (prod >= 0) return (q > 64'sd2147483647) ? VAL_MAX : val_t'(q);
    return (q > 64'sd2147483648) ? VAL_MIN : val_t'(-q);
  endfunction

  function automatic val_t length_sq(val_t a, val_t b, val_t c);
    return q_add(q_add(q_mul(a, a), q_mul(b, b)), q_mul(c, c));
  endfunction

  function automatic pis_out_t advance_point(pis_in_t w);
    val_t     p[3];
    val_t     acc[3];
    val_t     old[3];
    val_t     dt;
    val_t     s;
    val_t     vold;
    val_t     d;
    logic     use_cromer;
    pis_out_t r;
    p[0] = w.pos_x;
    p[1] = w.pos_y;
    p[2] = w.pos_z;
    r.skipped = 1'b0;
    if (w.req_type == REQ_INIT) begin
      for (int i = 0; i < 3; i++) begin
        dir_v[i] = (p[i] == VAL_MIN) ? VAL_MAX : -p[i];
        vel_v[i] = q_mul(p[i], amp_q);
      end
      r.skipped = 1'b1;
    end else if (w.frame_time > FRAME_MAX) begin
      r.skipped = 1'b1;
    end else begin
      dt = val_t'((longint'(w.frame_time) * 65536 + 327680) / 655360);
      s  = q_sub(length_sq(p[0], p[1], p[2]), rest_q);
      for (int i = 0; i < 3; i++) acc[i] = q_mul(dir_v[i], s);
      use_cromer = (mode_q == MODE_CROMER);
      if (mode_q == MODE_VERLET) begin
        for (int i = 0; i < 3; i++) begin
          old[i]    = prev_v[i];
          prev_v[i] = p[i];
        end
        use_cromer = (longint'(length_sq(old[0], old[1], old[2])) <= VERLET_MIN_SQ);
      end
      for (int i = 0; i < 3; i++) begin
        if (mode_q == MODE_EULER) begin
          vold     = vel_v[i];
          vel_v[i] = q_add(vold, q_mul(acc[i], dt));
          p[i]     = q_add(p[i], q_mul(vold, dt));
        end else if (use_cromer) begin
          vel_v[i] = q_add(vel_v[i], q_mul(acc[i], dt));
          p[i]     = q_add(p[i], q_mul(vel_v[i], dt));
        end else if (mode_q == MODE_VERLET) begin
          d    = q_add(q_sub(p[i], old[i]), q_mul(q_mul(acc[i], dt), dt));
          p[i] = q_add(p[i], d);
        end
      end
    end
    r.new_x = p[0];
    r.new_y = p[1];
    r.new_z = p[2];
    return r;
  endfunction

  function automatic pis_in_t mk(logic req, val_t x, val_t y, val_t z, logic [15:0] ft);
    pis_in_t w;
    w.req_type   = req;
    w.pos_x      = x;
    w.pos_y      = y;
    w.pos_z      = z;
    w.frame_time = ft;
    return w;
  endfunction

  function automatic void add_word(pis_in_t w);
    plan_row_t row;
    row      = '0;
    row.word = w;
    plan.push_back(row);
  endfunction

  function automatic void add_known(pis_in_t w, logic skip);
    plan_row_t row;
    row              = '0;
    row.word         = w;
    row.known        = 1'b1;
    row.want.new_x   = w.pos_x;
    row.want.new_y   = w.pos_y;
    row.want.new_z   = w.pos_z;
    row.want.skipped = skip;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [31:0] data);
    plan_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    plan.push_back(row);
  endfunction

  function automatic val_t rand_coord();
    val_t v;
    case ($urandom_range(0, 9))
      0: v = val_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = val_t'(int'($urandom_range(0, 24 * ONE)) - 12 * ONE);
    endcase
    return v;
  endfunction

  function automatic val_t pick_level(val_t typical, int span);
    val_t v;
    case ($urandom_range(0, 7))
      0: v = VAL_MIN;
      1: v = VAL_MAX;
      2: v = val_t'($urandom);
      3: v = typical;
      default: v = typical + val_t'(int'($urandom_range(0, 2 * span)) - span);
    endcase
    return v;
  endfunction

  task automatic note_mismatch(string what, pis_out_t want, pis_out_t got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch, %s: expected x=%h y=%h z=%h skipped=%b, got x=%h y=%h z=%h skipped=%b",
               what, want.new_x, want.new_y, want.new_z, want.skipped,
               got.new_x, got.new_y, got.new_z, got.skipped);
    end
  endtask

  task automatic send_word(input pis_in_t w, input logic known, input pis_out_t want,
                           output pis_out_t pred);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (w.req_type == REQ_INIT) inits++;
    else steps++;
    pred = advance_point(w);
    expected_q.push_back(known ? want : pred);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    burst_left = 0;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      REG_MODE: mode_q = mode_e'(data[1:0]);
      REG_AMP:  amp_q  = val_t'(data);
      REG_REST: rest_q = val_t'(data);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : result_check
    pis_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results++;
      if (out_data.skipped) skips++;
      if (expected_q.size() == 0) begin
        note_mismatch("word with nothing expected", '0, out_data);
      end else begin
        want = expected_q.pop_front();
        if (out_data.new_x !== want.new_x || out_data.new_y !== want.new_y ||
            out_data.new_z !== want.new_z || out_data.skipped !== want.skipped) begin
          note_mismatch($sformatf("result %0d", results), want, out_data);
        end
      end
    end
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 128);
    end
    stall_left--;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  initial begin : stimulus
    pis_out_t    pred;
    pis_in_t     w;
    mode_e       m;
    logic [15:0] ft;
    int          n;
    int          len;
    int          start;
    mode_q = MODE_EULER;
    amp_q  = val_t'(ONE);
    rest_q = val_t'(105 * ONE);
    for (int i = 0; i < 3; i++) begin
      dir_v[i]  = '0;
      vel_v[i]  = '0;
      prev_v[i] = '0;
      track[i]  = '0;
    end

    add_known(mk(REQ_STEP, ONE, 2 * ONE, 3 * ONE, 16'd1000), 1'b0);
    add_known(mk(REQ_STEP, VAL_MAX, VAL_MIN, 0, 16'(FRAME_MAX + 1)), 1'b1);
    add_known(mk(REQ_STEP, VAL_MIN, VAL_MAX, -1, 16'hFFFF), 1'b1);
    add_known(mk(REQ_INIT, VAL_MIN, VAL_MAX, -1, 16'h0000), 1'b1);
    add_word(mk(REQ_STEP, VAL_MIN, 0, VAL_MAX, 16'(FRAME_MAX)));
    add_known(mk(REQ_INIT, 6 * ONE, -8 * ONE, 0, 16'hFFFF), 1'b1);
    add_word(mk(REQ_STEP, 6 * ONE, -8 * ONE, 0, 16'd800));
    add_word(mk(REQ_STEP, 6 * ONE, -8 * ONE, ONE, 16'd0));
    add_cfg(REG_MODE, 32'(MODE_CROMER));
    add_known(mk(REQ_INIT, 3 * ONE, 4 * ONE, -5 * ONE, 16'd5), 1'b1);
    add_word(mk(REQ_STEP, 3 * ONE, 4 * ONE, -5 * ONE, 16'd2000));
    add_cfg(REG_MODE, 32'(MODE_VERLET));
    add_word(mk(REQ_STEP, 2 * ONE, ONE, -ONE, 16'd1500));
    add_word(mk(REQ_STEP, 2 * ONE, ONE, -ONE, 16'd1500));
    add_word(mk(REQ_STEP, 6554, 0, 0, 16'd300));
    add_word(mk(REQ_STEP, 6555, 0, 0, 16'd300));
    add_word(mk(REQ_STEP, ONE, ONE, 0, 16'd300));
    add_cfg(REG_AMP, VAL_MIN);
    add_cfg(REG_REST, VAL_MAX);
    add_known(mk(REQ_INIT, ONE, -ONE, VAL_MAX, 16'd7), 1'b1);
    add_word(mk(REQ_STEP, 2 * ONE, -ONE, ONE, 16'(FRAME_MAX)));
    add_cfg(REG_AMP, VAL_MAX);
    add_cfg(REG_REST, VAL_MIN);
    add_known(mk(REQ_INIT, -ONE, 2 * ONE, VAL_MIN, 16'd9), 1'b1);
    add_word(mk(REQ_STEP, -ONE, 2 * ONE, 3 * ONE, 16'd1200));
    add_cfg(REG_MODE, 32'hFFFF_FFFC | 32'(MODE_NONE));
    add_known(mk(REQ_STEP, 5 * ONE, -5 * ONE, ONE, 16'd100), 1'b0);
    add_known(mk(REQ_INIT, 7 * ONE, 0, -2 * ONE, 16'd100), 1'b1);
    add_cfg(REG_SPARE, $urandom);
    add_cfg(REG_MODE, 32'(MODE_EULER));
    add_cfg(REG_AMP, 32'(ONE));
    add_cfg(REG_REST, 32'(105 * ONE));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        drain_results();
        cfg_write(plan[k].idx, plan[k].data);
        cfg_valid <= 1'b0;
      end else begin
        send_word(plan[k].word, plan[k].known, plan[k].want, pred);
      end
    end

    n = 0;
    while (n < RANDOM_WORDS) begin
      drain_results();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 24);
      start   = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case ((start + k) % 3)
          0: begin
            case ($urandom_range(0, 9))
              0:       m = MODE_NONE;
              1, 2, 3: m = MODE_EULER;
              4, 5, 6: m = MODE_CROMER;
              default: m = MODE_VERLET;
            endcase
            cfg_write(REG_MODE, ($urandom & 32'hFFFF_FFFC) | 32'(m));
          end
          1: cfg_write(REG_AMP, pick_level(val_t'(ONE), 2 * ONE));
          default: cfg_write(REG_REST, pick_level(val_t'(105 * ONE), 200 * ONE));
        endcase
      end
      if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, $urandom);
      cfg_valid <= 1'b0;

      len = $urandom_range(20, 50);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 9))
          0: ft = 16'($urandom);
          1: ft = 16'(FRAME_MAX + $urandom_range(0, 1));
          2: ft = 16'hFFFF;
          default: ft = 16'($urandom_range(0, FRAME_MAX));
        endcase
        case ((j == 0) ? 0 : $urandom_range(0, 19))
          0: w = mk(REQ_INIT, rand_coord(), rand_coord(), rand_coord(), 16'($urandom));
          1: w = mk(REQ_STEP, rand_coord(), rand_coord(), rand_coord(), ft);
          default: w = mk(REQ_STEP, track[0], track[1], track[2], ft);
        endcase
        send_word(w, 1'b0, '0, pred);
        track[0] = pred.new_x;
        track[1] = pred.new_y;
        track[2] = pred.new_z;
        n++;
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    $display("covered %0d init and %0d step words across %0d register writes", inits, steps,
             cfg_writes);
    $display("checked %0d results, %0d of them skipped, %0d mismatches", results, skips, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pis_pkg.sv
rtl/pis_lane.sv
rtl/pis_merge.sv
rtl/particle_integrator_step.sv
tb/sv/tb_particle_integrator_step.sv
